>>> sv/tqlc_pkg.sv
// Shared constants, codes and types for the timer queue.
`default_nettype none
package tqlc_pkg;
  localparam int DEPTH = 16;
  localparam int IW = $clog2(DEPTH);
  localparam int CW = IW + 1;
  localparam int DLW = 32;
  localparam int OWNW = 8;
  localparam int ACTW = 4;
  localparam int ENTW = DLW + OWNW + ACTW;
  localparam int WAITW = 25;
  localparam logic [WAITW-1:0] WAIT_MAX = 25'd16777215;
  localparam logic [WAITW-1:0] WAIT_NONE = '1;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_WAIT    = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ACK    = 4'b0010,
    S_SCAN   = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;
endpackage
`default_nettype wire

>>> sv/tqlc_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none
module tqlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> sv/timer_queue_lazy_cancel.sv
// Top level of the deadline-ordered timer queue with lazy cancellation.
`default_nettype none
// Timer queue for DEPTH timers. Deadline, owner and action live in one RAM;
// valid, cancelled and insertion rank are per-slot flops. Add and unused
// commands go straight to the ack state. Cancel and every head search sweep
// the RAM; a tick runs one sweep per removed entry plus one for the wait
// report. Results leave through an output register, one per cycle at most.
module timer_queue_lazy_cancel
  import tqlc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        command,
  input  wire logic [OWNW-1:0]   owner,
  input  wire logic [23:0]       timeout,
  input  wire logic [ACTW-1:0]   action,
  input  wire logic [DLW-1:0]    now_ms,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             kind,
  output logic                   status,
  output logic [OWNW-1:0]        expired_owner,
  output logic [ACTW-1:0]        expired_action,
  output logic signed [WAITW-1:0] next_wait,
  output logic                   last
);
  state_t state;
  cmd_t cmd;
  logic [OWNW-1:0] cur_owner;
  logic [DLW-1:0] cur_now;
  logic ack_status;

  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] cancelled;
  logic [IW-1:0] rank [DEPTH];
  logic [CW-1:0] count;

  logic [CW-1:0] cnt;
  logic rd_v;
  logic [IW-1:0] rd_idx;
  logic [ENTW-1:0] rdata;

  logic found;
  logic [IW-1:0] best_idx;
  logic [DLW-1:0] best_dl;
  logic [IW-1:0] best_rank;
  logic [OWNW-1:0] best_own;
  logic [ACTW-1:0] best_act;

  logic accept, out_free;
  logic [IW-1:0] free_idx;
  logic full;
  logic [32:0] dl_sum;
  logic [DLW-1:0] dl_new;
  logic ram_we;
  logic [IW-1:0] raddr;

  logic [DLW-1:0] e_dl;
  logic [OWNW-1:0] e_own;
  logic [ACTW-1:0] e_act;
  logic [IW-1:0] e_rank;
  logic take;
  logic [DLW-1:0] diff;
  logic [WAITW-1:0] wait_val;

  logic head_wait, head_emit, out_load;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // pick the lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) free_idx = IW'(i);
    end
  end
  assign full = &valid;

  // saturated deadline
  assign dl_sum = {1'b0, now_ms} + {9'd0, timeout};
  assign dl_new = dl_sum[32] ? '1 : dl_sum[DLW-1:0];
  assign ram_we = accept && (cmd_t'(command) == CMD_ADD) && !full;
  assign raddr = cnt[IW-1:0];

  tqlc_ram #(.WIDTH(ENTW), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(free_idx),
    .wdata({dl_new, owner, action}),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign e_dl = rdata[ENTW-1 -: DLW];
  assign e_own = rdata[ACTW +: OWNW];
  assign e_act = rdata[ACTW-1:0];
  assign e_rank = rank[rd_idx];

  // compare the returned entry against the best so far
  always_comb begin
    take = 1'b0;
    if (rd_v && valid[rd_idx]) begin
      if (cmd == CMD_CANCEL) begin
        take = (e_own == cur_owner) && (!found || e_rank > best_rank);
      end else begin
        take = !found || (e_dl < best_dl) || (e_dl == best_dl && e_rank < best_rank);
      end
    end
  end

  // wait until the head deadline, saturated
  assign diff = best_dl - cur_now;
  assign wait_val = (diff > DLW'(WAIT_MAX)) ? WAIT_MAX : WAITW'(diff);

  // classify the head and decide when the result register loads
  assign head_wait = !found || (!cancelled[best_idx] && best_dl > cur_now);
  assign head_emit = !head_wait && !cancelled[best_idx] && best_act != '0;
  assign out_load = out_free &&
                    ((state == S_ACK) || (state == S_DECIDE && (head_wait || head_emit)));

  // control, slot flags and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      cancelled <= '0;
      count <= '0;
      out_valid <= 1'b0;
      rd_v <= 1'b0;
      cnt <= '0;
      found <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd <= cmd_t'(command);
            cur_owner <= owner;
            cur_now <= now_ms;
            ack_status <= 1'b0;
            cnt <= '0;
            rd_v <= 1'b0;
            found <= 1'b0;
            unique case (cmd_t'(command))
              CMD_ADD: begin
                state <= S_ACK;
                if (full) begin
                  ack_status <= 1'b1;
                end else begin
                  valid[free_idx] <= 1'b1;
                  cancelled[free_idx] <= 1'b0;
                  rank[free_idx] <= count[IW-1:0];
                  count <= count + 1'b1;
                end
              end
              CMD_CANCEL, CMD_TICK: state <= S_SCAN;
              default: state <= S_ACK;
            endcase
          end
        end
        S_ACK: begin
          if (out_free) begin
            kind <= KIND_ACK;
            status <= ack_status;
            expired_owner <= '0;
            expired_action <= '0;
            next_wait <= '0;
            last <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          // sweep the RAM, one read per cycle
          rd_v <= (cnt < CW'(DEPTH));
          rd_idx <= raddr;
          if (cnt < CW'(DEPTH)) cnt <= cnt + 1'b1;
          if (take) begin
            found <= 1'b1;
            best_idx <= rd_idx;
            best_dl <= e_dl;
            best_rank <= e_rank;
            best_own <= e_own;
            best_act <= e_act;
          end
          if (cnt == CW'(DEPTH) && !rd_v) begin
            if (cmd == CMD_CANCEL) begin
              if (found) cancelled[best_idx] <= 1'b1;
              state <= S_ACK;
            end else begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (head_wait) begin
            // report the wait and finish
            if (out_free) begin
              kind <= KIND_WAIT;
              status <= 1'b0;
              expired_owner <= '0;
              expired_action <= '0;
              next_wait <= found ? wait_val : WAIT_NONE;
              last <= 1'b1;
              state <= S_IDLE;
            end
          end else if (cancelled[best_idx] || best_act == '0 || out_free) begin
            // emit if live with a handler, then drop the head and rescan
            if (head_emit) begin
              kind <= KIND_EXPIRED;
              status <= 1'b0;
              expired_owner <= best_own;
              expired_action <= best_act;
              next_wait <= '0;
              last <= 1'b0;
            end
            valid[best_idx] <= 1'b0;
            cancelled[best_idx] <= 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
              if (valid[i] && rank[i] > best_rank) rank[i] <= rank[i] - 1'b1;
            end
            if (count != '0) count <= count - 1'b1;
            cnt <= '0;
            rd_v <= 1'b0;
            found <= 1'b0;
            state <= S_SCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> test/timer_queue_lazy_cancel_test.sv
// Self-checking testbench for the timer queue with lazy cancellation.
`timescale 1ns / 100ps
`default_nettype none
module timer_queue_lazy_cancel_test;
  import tqlc_pkg::*;

  typedef struct packed {
    logic [1:0]       kind;
    logic             status;
    logic [OWNW-1:0]  owner;
    logic [ACTW-1:0]  action;
    logic [WAITW-1:0] wait_ms;
    logic             last;
  } timer_result_t;

  typedef struct packed {
    logic [1:0]      command;
    logic [OWNW-1:0] owner;
    logic [23:0]     timeout;
    logic [ACTW-1:0] action;
    logic [31:0]     now;
    logic            typed;
    timer_result_t   typed_result;
  } timer_request_t;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 4 * (DEPTH + 3) * (DEPTH + 2);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command = CMD_ADD;
  logic [OWNW-1:0] owner = '0;
  logic [23:0] timeout = '0;
  logic [ACTW-1:0] action = '0;
  logic [DLW-1:0] now_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] kind;
  logic status;
  logic [OWNW-1:0] expired_owner;
  logic [ACTW-1:0] expired_action;
  logic signed [WAITW-1:0] next_wait;
  logic last;

  timer_queue_lazy_cancel dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .owner(owner), .timeout(timeout), .action(action),
    .now_ms(now_ms), .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .status(status), .expired_owner(expired_owner),
    .expired_action(expired_action), .next_wait(next_wait), .last(last)
  );

  // Generate the clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the queue state
  logic [31:0]     shadow_deadline [DEPTH];
  logic [OWNW-1:0] shadow_owner [DEPTH];
  logic [ACTW-1:0] shadow_action [DEPTH];
  logic            shadow_cancelled [DEPTH];
  logic            shadow_valid [DEPTH];
  int              shadow_rank [DEPTH];
  int              shadow_count;

  timer_result_t expected_results [$];
  int  error_count = 0;
  int  cycle_count = 0;
  bit  quiet_out = 1'b0;
  logic [31:0] clock_ms = '0;

  function automatic timer_result_t make_result(logic [1:0] k, logic s, logic [OWNW-1:0] o,
                                                logic [ACTW-1:0] a, logic [WAITW-1:0] w,
                                                logic l);
    timer_result_t r;
    r.kind = k; r.status = s; r.owner = o; r.action = a; r.wait_ms = w; r.last = l;
    return r;
  endfunction

  function automatic int find_head();
    int best;
    best = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (!shadow_valid[i]) continue;
      if (best < 0 || shadow_deadline[i] < shadow_deadline[best] ||
          (shadow_deadline[i] == shadow_deadline[best] && shadow_rank[i] < shadow_rank[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic void retire_slot(int s);
    shadow_valid[s] = 1'b0;
    shadow_cancelled[s] = 1'b0;
    for (int i = 0; i < DEPTH; i++)
      if (shadow_valid[i] && shadow_rank[i] > shadow_rank[s]) shadow_rank[i]--;
    if (shadow_count > 0) shadow_count--;
  endfunction

  // Compute the results of one transaction and queue them
  function automatic void predict_timer(timer_request_t t);
    int slot, h;
    logic [32:0] sum;
    logic [31:0] diff;
    logic [WAITW-1:0] w;
    bit done;
    case (t.command)
      CMD_ADD: begin
        slot = -1;
        for (int i = 0; i < DEPTH; i++)
          if (!shadow_valid[i] && slot < 0) slot = i;
        if (slot < 0) begin
          expected_results.push_back(make_result(KIND_ACK, 1'b1, '0, '0, '0, 1'b1));
        end else begin
          sum = {1'b0, t.now} + {9'b0, t.timeout};
          shadow_deadline[slot] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          shadow_owner[slot] = t.owner;
          shadow_action[slot] = t.action;
          shadow_cancelled[slot] = 1'b0;
          shadow_valid[slot] = 1'b1;
          shadow_rank[slot] = shadow_count;
          shadow_count++;
          expected_results.push_back(make_result(KIND_ACK, 1'b0, '0, '0, '0, 1'b1));
        end
      end
      CMD_CANCEL: begin
        slot = -1;
        for (int i = 0; i < DEPTH; i++)
          if (shadow_valid[i] && shadow_owner[i] == t.owner &&
              (slot < 0 || shadow_rank[i] > shadow_rank[slot])) slot = i;
        if (slot >= 0) shadow_cancelled[slot] = 1'b1;
        expected_results.push_back(make_result(KIND_ACK, 1'b0, '0, '0, '0, 1'b1));
      end
      CMD_TICK: begin
        done = 1'b0;
        for (int n = 0; n < DEPTH && !done; n++) begin
          h = find_head();
          if (h < 0) done = 1'b1;
          else if (shadow_cancelled[h]) retire_slot(h);
          else if (shadow_deadline[h] > t.now) done = 1'b1;
          else begin
            if (shadow_action[h] != '0)
              expected_results.push_back(make_result(KIND_EXPIRED, 1'b0, shadow_owner[h],
                                                     shadow_action[h], '0, 1'b0));
            retire_slot(h);
          end
        end
        w = WAIT_NONE;
        done = 1'b0;
        for (int n = 0; n <= DEPTH && !done; n++) begin
          h = find_head();
          if (h < 0) done = 1'b1;
          else if (shadow_cancelled[h]) retire_slot(h);
          else begin
            if (shadow_deadline[h] <= t.now) w = '0;
            else begin
              diff = shadow_deadline[h] - t.now;
              w = (diff > 32'(WAIT_MAX)) ? WAIT_MAX : diff[WAITW-1:0];
            end
            done = 1'b1;
          end
        end
        expected_results.push_back(make_result(KIND_WAIT, 1'b0, '0, '0, w, 1'b1));
      end
      default: expected_results.push_back(make_result(KIND_ACK, 1'b0, '0, '0, '0, 1'b1));
    endcase
  endfunction

  // Drive one transaction and wait for acceptance; valid drops only for an idle burst
  task automatic send_timer(timer_request_t t, bit idle_ok);
    int gap;
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (t.typed) begin
      predict_timer(t);
      void'(expected_results.pop_back());
      expected_results.push_back(t.typed_result);
    end else begin
      predict_timer(t);
    end
    in_valid <= 1'b1;
    command <= t.command; owner <= t.owner; timeout <= t.timeout;
    action <= t.action; now_ms <= t.now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic timer_request_t plain(logic [1:0] c, logic [OWNW-1:0] o, logic [23:0] tm,
                                           logic [ACTW-1:0] a, logic [31:0] n);
    timer_request_t t;
    t = '0;
    t.command = c; t.owner = o; t.timeout = tm; t.action = a; t.now = n;
    return t;
  endfunction

  function automatic timer_request_t typed(timer_request_t t, timer_result_t r);
    t.typed = 1'b1;
    t.typed_result = r;
    return t;
  endfunction

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    timer_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0d", $time, kind);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
          error_count++;
        end
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          error_count++;
        end
        if (expired_owner !== want.owner) begin
          $display("%0t: owner expected %0d actual %0d", $time, want.owner, expired_owner);
          error_count++;
        end
        if (expired_action !== want.action) begin
          $display("%0t: action expected %0d actual %0d", $time, want.action, expired_action);
          error_count++;
        end
        if (next_wait !== want.wait_ms) begin
          $display("%0t: next_wait expected %0d actual %0d", $time,
                   $signed(want.wait_ms), next_wait);
          error_count++;
        end
        if (last !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, last);
          error_count++;
        end
      end
    end
  end

  // Stall the result side in random bursts
  always @(posedge clk) begin
    int burst;
    if (quiet_out || rst) out_stall <= 1'b0;
    else if (out_stall) begin
      if (burst > 0) burst--;
      if (burst == 0) out_stall <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      burst = $urandom_range(1, 5);
      out_stall <= 1'b1;
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Random transaction, mostly well-formed traffic on a small set of owners
  function automatic timer_request_t random_timer();
    timer_request_t t;
    int r;
    t = '0;
    r = $urandom_range(0, 99);
    t.command = (r < 45) ? CMD_ADD : (r < 65) ? CMD_CANCEL : (r < 97) ? CMD_TICK : CMD_NOP;
    t.owner = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0: t.timeout = 24'($urandom);
      1: t.timeout = 24'hFF_FFFF;
      2: t.timeout = '0;
      default: t.timeout = 24'($urandom_range(0, 200));
    endcase
    t.action = ($urandom_range(0, 5) == 0) ? '0 : 4'($urandom);
    r = $urandom_range(0, 19);
    if (r == 0) clock_ms = 32'hFFFF_FF00 + 32'($urandom_range(0, 255));
    else if (r == 1 && clock_ms[31]) clock_ms = 32'($urandom_range(0, 50));
    else if (r == 2) clock_ms = clock_ms + 32'($urandom);
    else if (r < 10) clock_ms = clock_ms + 32'($urandom_range(0, 60));
    t.now = clock_ms;
    return t;
  endfunction

  timer_request_t directed [$];

  initial begin
    int wait_count;
    for (int i = 0; i < DEPTH; i++) begin
      shadow_valid[i] = 1'b0; shadow_cancelled[i] = 1'b0; shadow_rank[i] = 0;
    end
    shadow_count = 0;

    // Directed stimulus table
    directed.push_back(typed(plain(CMD_TICK, 0, 0, 0, 0),
                             make_result(KIND_WAIT, 1'b0, '0, '0, WAIT_NONE, 1'b1)));
    directed.push_back(typed(plain(CMD_CANCEL, 8'hFF, 0, 0, 0),
                             make_result(KIND_ACK, 1'b0, '0, '0, '0, 1'b1)));
    directed.push_back(typed(plain(CMD_NOP, 8'hFF, 24'hFF_FFFF, 4'hF, 32'hFFFF_FFFF),
                             make_result(KIND_ACK, 1'b0, '0, '0, '0, 1'b1)));
    directed.push_back(plain(CMD_ADD, 8'hFF, 24'hFF_FFFF, 4'hF, 32'hFFFF_FFF0));
    directed.push_back(plain(CMD_ADD, 8'h00, 24'd0, 4'h0, 32'd100));
    directed.push_back(plain(CMD_ADD, 8'h01, 24'd5, 4'h1, 32'd100));
    directed.push_back(plain(CMD_ADD, 8'h02, 24'd5, 4'h2, 32'd100));
    directed.push_back(plain(CMD_ADD, 8'h01, 24'd5, 4'h3, 32'd100));
    directed.push_back(plain(CMD_CANCEL, 8'h01, 0, 0, 32'd100));
    directed.push_back(plain(CMD_CANCEL, 8'h01, 0, 0, 32'd100));
    directed.push_back(plain(CMD_TICK, 0, 0, 0, 32'd105));
    directed.push_back(plain(CMD_TICK, 0, 0, 0, 32'd50));
    for (int i = 0; i < DEPTH; i++)
      directed.push_back(plain(CMD_ADD, 8'(i), 24'(i), 4'hA, 32'd200));
    directed.push_back(plain(CMD_TICK, 0, 0, 0, 32'hFFFF_FFFF));
    directed.push_back(plain(CMD_TICK, 0, 0, 0, 32'hFFFF_FFFF));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_timer(directed[i], 1'b1);
    in_valid <= 1'b0;

    // Hold the sender until the queue of expectations drains
    while (expected_results.size() != 0) @(posedge clk);

    clock_ms = 32'd1000;
    for (int i = 0; i < 500; i++) send_timer(random_timer(), i < 420);
    quiet_out = 1'b1;
    for (int i = 0; i < 40; i++) send_timer(random_timer(), 1'b0);
    in_valid <= 1'b0;

    wait_count = 0;
    while (expected_results.size() != 0 && wait_count < CYCLE_LIMIT) begin
      @(posedge clk);
      wait_count++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
